// ===== rtl/core/qpa_pkg.sv =====
// Shared types and constants of the quantized post-processing ALU.
package qpa_pkg;

   typedef enum logic [2:0] {
      FUNC_MAC     = 3'd0,
      FUNC_ADD32   = 3'd1,
      FUNC_SUB32   = 3'd2,
      FUNC_REQUANT = 3'd3,
      FUNC_RELU    = 3'd4,
      FUNC_CLIP    = 3'd5,
      FUNC_SIGMOID = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      CSR_SCALE_MULT  = 2'd0,
      CSR_SCALE_SHIFT = 2'd1,
      CSR_CLIP_LOW    = 2'd2,
      CSR_CLIP_HIGH   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   localparam logic signed [31:0] SCALE_MULT_RESET  = 32'sd1;
   localparam logic signed [6:0]  SCALE_SHIFT_RESET = 7'sd0;
   localparam logic signed [15:0] CLIP_LOW_RESET    = -16'sd32768;
   localparam logic signed [15:0] CLIP_HIGH_RESET   = 16'sd32767;

   localparam logic signed [15:0] Q16_MAX = 16'sd32767;
   localparam logic signed [15:0] Q16_MIN = -16'sd32768;
   localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;
   localparam logic signed [6:0]  LSHIFT_LIMIT = -7'sd30;
   localparam logic signed [6:0]  SIG_SLOPE = 7'sd43;
   localparam logic signed [15:0] SIG_OFFSET = 16'sd128;
   localparam logic [8:0]         SIG_T_MAX = 9'd256;

endpackage

// ===== rtl/core/qpa_requant.sv =====
// Four-stage requant: split multiply, product sum, magnitude and left shift, rounding shift.
module qpa_requant (
   input  logic                       clock,
   input  qpa_pkg::stage_en_type      en,
   input  logic signed [63:0]         acc_in,
   input  logic signed [31:0]         scale_mult,
   input  logic signed [6:0]          scale_shift,
   output logic signed [15:0]         result
);
   import qpa_pkg::*;

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) begin
         r = Q16_MAX;
      end else if (v < -64'sd32768) begin
         r = Q16_MIN;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic signed [64:0] pp0_full;
   logic [63:0]        pp1_full;
   logic [63:0]        pp0_ff;
   logic [31:0]        pp1_ff;
   logic               acc_neg1_ff;

   logic [63:0]        prod_in;
   logic [63:0]        prod_ff;
   logic               acc_neg2_ff;

   logic [6:0]         nshift;
   logic [63:0]        lsh;
   logic               neg_in;
   logic [63:0]        mag_in;
   logic signed [15:0] lsat_in;
   logic               neg3_ff;
   logic [63:0]        mag3_ff;
   logic signed [15:0] lsat3_ff;
   logic               acc_neg3_ff;

   logic [5:0]         rshift;
   logic [63:0]        rnd;
   logic [63:0]        rsum;
   logic [63:0]        q;
   logic signed [15:0] result_in;
   logic signed [15:0] result_ff;

   assign pp0_full = $signed({1'b0, acc_in[31:0]}) * scale_mult;
   assign pp1_full = acc_in[63:32] * scale_mult;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         pp0_ff      <= pp0_full[63:0];
         pp1_ff      <= pp1_full[31:0];
         acc_neg1_ff <= acc_in[63];
      end
   end

   assign prod_in = pp0_ff + {pp1_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (en.s2) begin
         prod_ff     <= prod_in;
         acc_neg2_ff <= acc_neg1_ff;
      end
   end

   assign nshift  = (scale_shift < 7'sd0) ? 7'(~scale_shift + 7'd1) : 7'd0;
   assign lsh     = prod_ff << nshift[4:0];
   assign neg_in  = prod_ff[63];
   assign mag_in  = neg_in ? (~prod_ff + 64'd1) : prod_ff;
   assign lsat_in = sat16($signed(lsh));

   always_ff @(posedge clock) begin
      if (en.s3) begin
         neg3_ff     <= neg_in;
         mag3_ff     <= mag_in;
         lsat3_ff    <= lsat_in;
         acc_neg3_ff <= acc_neg2_ff;
      end
   end

   assign rshift = scale_shift[5:0];
   assign rnd    = 64'd1 << (rshift - 6'd1);
   assign rsum   = mag3_ff + rnd;
   assign q      = rsum >> rshift;

   always_comb begin
      if (scale_shift < LSHIFT_LIMIT) begin
         result_in = acc_neg3_ff ? Q16_MIN : Q16_MAX;
      end else if (scale_shift <= 7'sd0) begin
         result_in = lsat3_ff;
      end else if (neg3_ff) begin
         result_in = (q > 64'd32768) ? Q16_MIN : 16'(~q[15:0] + 16'd1);
      end else begin
         result_in = (q > 64'd32767) ? Q16_MAX : q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== rtl/core/quantized_postprocess_alu_top.sv =====
// Top level of the quantized post-processing ALU: four-stage pipeline and register file.
//
// A request on the req_ channel carries func, a 64-bit accumulator and two 32-bit operands.
// Each request yields exactly one response on the rsp_ channel, in request order.
// The function codes are multiply-accumulate, saturating 32-bit add and subtract,
// requantization to int16, ReLU, clip and a Q8 to Q15 hard sigmoid; code 7 returns zero.
// The csr_ channel writes scale_mult, scale_shift, clip_low and clip_high by index and is
// always ready; registers must only be written while no request is in flight.
// The pipeline has four register stages, and a response is valid once its request reaches
// the last stage. A new request can be accepted every cycle while rsp_ready is high.
// The depth is set by the requantization path: split 64 by 32 multiply, product sum,
// magnitude and left shift, then the rounding right shift.
// Each stage holds its own valid bit, so a stalled receiver only stops a stage that is full
// along with every stage after it, and req_ready drops only when all four stages hold
// requests and the receiver stalls.
// Reset empties the pipeline and loads the register reset values: multiplier one,
// shift zero and the full int16 clip range.
module quantized_postprocess_alu_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [63:0] req_acc_in,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import qpa_pkg::*;

   logic signed [31:0] scale_mult_ff;
   logic signed [6:0]  scale_shift_ff;
   logic signed [15:0] clip_low_ff;
   logic signed [15:0] clip_high_ff;

   stage_en_type       en;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [15:0] a16;
   logic signed [7:0]  b8;
   logic signed [23:0] mac_prod_in;
   logic signed [32:0] sum_in;
   logic signed [22:0] sig_prod_in;
   logic signed [15:0] small_in;

   logic [2:0]         func1_ff;
   logic signed [63:0] acc1_ff;
   logic signed [23:0] mac_prod1_ff;
   logic signed [32:0] sum1_ff;
   logic signed [22:0] sig_prod1_ff;
   logic signed [15:0] small1_ff;

   logic signed [31:0] sat32_in;
   logic signed [15:0] t_raw;
   logic [8:0]         t_in;
   logic signed [63:0] r2_in;
   logic [2:0]         func2_ff;
   logic [8:0]         t2_ff;
   logic signed [63:0] r2_ff;

   logic [23:0]        tmul;
   logic signed [63:0] r3_in;
   logic [2:0]         func3_ff;
   logic signed [63:0] r3_ff;

   logic [2:0]         func4_ff;
   logic signed [63:0] r4_ff;
   logic signed [15:0] rq_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mult_ff  <= SCALE_MULT_RESET;
         scale_shift_ff <= SCALE_SHIFT_RESET;
         clip_low_ff    <= CLIP_LOW_RESET;
         clip_high_ff   <= CLIP_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCALE_MULT:  scale_mult_ff  <= csr_wdata;
            CSR_SCALE_SHIFT: scale_shift_ff <= csr_wdata[6:0];
            CSR_CLIP_LOW:    clip_low_ff    <= csr_wdata[15:0];
            CSR_CLIP_HIGH:   clip_high_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign en.s4     = !v4_ff || rsp_ready;
   assign en.s3     = !v3_ff || en.s4;
   assign en.s2     = !v2_ff || en.s3;
   assign en.s1     = !v1_ff || en.s2;
   assign req_ready = en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en.s4) v4_ff <= v3_ff;
      end
   end

   assign a16         = req_operand_a[15:0];
   assign b8          = req_operand_b[7:0];
   assign mac_prod_in = a16 * b8;
   assign sum_in      = (req_func == FUNC_SUB32) ?
                        (33'(req_operand_a) - 33'(req_operand_b)) :
                        (33'(req_operand_a) + 33'(req_operand_b));
   assign sig_prod_in = 23'(a16) * 23'(SIG_SLOPE);

   always_comb begin
      if (req_func == FUNC_RELU) begin
         small_in = a16[15] ? 16'sd0 : a16;
      end else if (a16 < clip_low_ff) begin
         small_in = clip_low_ff;
      end else if (a16 > clip_high_ff) begin
         small_in = clip_high_ff;
      end else begin
         small_in = a16;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         func1_ff     <= req_func;
         acc1_ff      <= req_acc_in;
         mac_prod1_ff <= mac_prod_in;
         sum1_ff      <= sum_in;
         sig_prod1_ff <= sig_prod_in;
         small1_ff    <= small_in;
      end
   end

   assign sat32_in = (sum1_ff[32] != sum1_ff[31]) ? (sum1_ff[32] ? Q32_MIN : Q32_MAX) :
                     sum1_ff[31:0];
   assign t_raw    = 16'(sig_prod1_ff >>> 8) + SIG_OFFSET;
   assign t_in     = t_raw[15] ? 9'd0 : ((t_raw > 16'sd256) ? SIG_T_MAX : t_raw[8:0]);

   always_comb begin
      case (func1_ff)
         FUNC_MAC:                r2_in = acc1_ff + 64'(mac_prod1_ff);
         FUNC_ADD32, FUNC_SUB32:  r2_in = 64'(sat32_in);
         FUNC_RELU, FUNC_CLIP:    r2_in = 64'(small1_ff);
         default:                 r2_in = 64'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         func2_ff <= func1_ff;
         t2_ff    <= t_in;
         r2_ff    <= r2_in;
      end
   end

   assign tmul  = {t2_ff, 15'd0} - 24'(t2_ff);
   assign r3_in = (func2_ff == FUNC_SIGMOID) ? $signed({48'd0, tmul[23:8]}) : r2_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         func3_ff <= func2_ff;
         r3_ff    <= r3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         func4_ff <= func3_ff;
         r4_ff    <= r3_ff;
      end
   end

   qpa_requant u_requant (
      .clock       (clock),
      .en          (en),
      .acc_in      (req_acc_in),
      .scale_mult  (scale_mult_ff),
      .scale_shift (scale_shift_ff),
      .result      (rq_result)
   );

   assign rsp_valid  = v4_ff;
   assign rsp_result = (func4_ff == FUNC_REQUANT) ? 64'(rq_result) : r4_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted request did not enter the first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready) |-> !req_ready)
      else $error("full pipeline accepted a request under stall");

   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      (!v1_ff || !v2_ff || !v3_ff || !v4_ff) |-> req_ready)
      else $error("pipeline with an empty stage refused a request");

   a_relu_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && func4_ff == FUNC_RELU) |-> !rsp_result[63])
      else $error("relu response is negative");

   a_sigmoid_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && func4_ff == FUNC_SIGMOID) |-> (rsp_result[63:15] == 49'd0))
      else $error("hard sigmoid response out of Q15 range");

endmodule
